@@ hdl/tcra_pkg.sv @@
// Shared types, keyword tables and reply helpers for the text command register access block.
`default_nettype none

package tcra_pkg;

    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [12:0] NUM_SAT  = 13'd8191;

    // Keyword slots in the candidate mask; the top bit marks an all-digit token.
    localparam int KW_GET     = 0;
    localparam int KW_SET     = 1;
    localparam int KW_TEMP    = 2;
    localparam int KW_TARGET  = 5;
    localparam int CAND_DIGIT = 6;
    localparam logic [6:0] CAND_ALL = 7'h7F;

    // Keyword text, one row per keyword, first character in byte 0.
    localparam logic [5:0][5:0][7:0] KW_TEXT = {
        {"T", "E", "G", "R", "A", "T"},
        {"S", "U", "T", "A", "T", "S"},
        {8'h00, "R", "E", "M", "I", "T"},
        {8'h00, 8'h00, "P", "M", "E", "T"},
        {8'h00, 8'h00, 8'h00, "T", "E", "S"},
        {8'h00, 8'h00, 8'h00, "T", "E", "G"}
    };
    localparam logic [5:0][2:0] KW_LEN = {3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd3};

    // Reply texts, first character in byte 0.
    typedef logic [2:0][7:0] txt_t;
    localparam txt_t TXT_OK  = {8'h00, "K", "O"};
    localparam txt_t TXT_CMD = {"D", "M", "C"};
    localparam txt_t TXT_VAR = {"R", "A", "V"};
    localparam txt_t TXT_INT = {"T", "N", "I"};

    localparam logic [1:0] CFG_TIMER_LIMIT = 2'd0;
    localparam logic [1:0] CFG_TARGET_LOW  = 2'd1;
    localparam logic [1:0] CFG_TARGET_HIGH = 2'd2;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_GET  = 2'd1,
        CMD_SET  = 2'd2
    } cmd_kind_t;

    typedef enum logic [2:0] {
        VAR_NONE   = 3'd0,
        VAR_TEMP   = 3'd1,
        VAR_TIMER  = 3'd2,
        VAR_STATUS = 3'd3,
        VAR_TARGET = 3'd4
    } var_t;

    typedef enum logic [1:0] {
        VERD_PENDING = 2'd0,
        VERD_OK      = 2'd1,
        VERD_FAIL    = 2'd2
    } verdict_t;

    // Reply handed from the parser to the reply serializer.
    typedef struct packed {
        logic        load;
        logic        num;
        logic        ok;
        logic [2:0]  len;
        txt_t        txt;
        logic [11:0] value;
    } reply_req_t;

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (k < 3'd6 && pos < 3'd6) begin
            ch = KW_TEXT[k][pos];
        end
        return ch;
    endfunction

    function automatic logic [13:0] pow10(input logic [1:0] place);
        logic [13:0] p;
        unique case (place)
            2'd0: p = 14'd1;
            2'd1: p = 14'd10;
            2'd2: p = 14'd100;
            default: p = 14'd1000;
        endcase
        return p;
    endfunction

    // Decimal digit at the given place; the remainder is below ten of that place.
    function automatic logic [3:0] digit_of(input logic [11:0] rem, input logic [1:0] place);
        logic [3:0]  d;
        logic [13:0] scale;
        d     = 4'd0;
        scale = pow10(place);
        for (int i = 1; i < 10; i++) begin
            if ({2'b00, rem} >= 14'(i) * scale) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hdl/tcra_parser.sv @@
// Token parser, variable store and reply selection for the text command register access block.
`default_nettype none

module tcra_parser
    import tcra_pkg::*;
#(
    parameter int TEMP_BITS = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        adv,
    input  wire logic        req_type,
    input  wire logic [7:0]  char_byte,
    input  wire logic        is_final,
    input  wire logic [9:0]  temp_sample,
    input  wire logic [11:0] timer_limit,
    input  wire logic [6:0]  target_low,
    input  wire logic [6:0]  target_high,
    output reply_req_t       rep_req
);

    logic [TEMP_BITS-1:0] temp_reg, temp_next;
    logic [11:0]          timer_reg, timer_next;
    logic                 status_reg, status_next;
    logic [6:0]           target_reg, target_next;
    logic [1:0]           tok_idx_reg, tok_idx_next;
    logic [2:0]           pos_reg, pos_next;
    logic [6:0]           cand_reg, cand_next;
    logic [12:0]          acc_reg, acc_next;
    cmd_kind_t            kind_reg, kind_next;
    var_t                 var_reg, var_next;
    verdict_t             verd_reg, verd_next;

    logic [7:0]  c;
    logic        is_space, is_digit, cmd_item, final_item, do_end;
    logic [6:0]  upd_cand, tok_cand;
    logic [2:0]  upd_pos, tok_pos;
    logic [12:0] upd_acc, tok_acc;
    logic [16:0] acc_wide;
    logic [5:0]  hit;
    var_t        tok_var;
    cmd_kind_t   kind_e;
    var_t        var_e;
    verdict_t    verd_e;
    logic [11:0] timer_e;
    logic        status_e;
    logic [6:0]  target_e;
    logic [TEMP_BITS+11:0] temp_wide;
    logic [TEMP_BITS+9:0]  smp_wide;
    logic [11:0] temp_rd, val;

    always_comb begin
        c = char_byte;
        if (char_byte >= "a" && char_byte <= "z") begin
            c = char_byte - 8'd32;
        end
        is_space   = (c == CH_SPACE);
        is_digit   = (c >= "0" && c <= "9");
        cmd_item   = !req_type;
        final_item = cmd_item && is_final;

        // Narrow the keyword candidates by the character at this position.
        upd_cand = cand_reg;
        for (int k = 0; k < 6; k++) begin
            if (pos_reg >= KW_LEN[k] || kw_char(3'(k), pos_reg) != c) begin
                upd_cand[k] = 1'b0;
            end
        end
        if (!is_digit) begin
            upd_cand[CAND_DIGIT] = 1'b0;
        end

        acc_wide = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {9'd0, c - CH_ZERO};
        upd_acc  = acc_reg;
        if (is_digit) begin
            upd_acc = (acc_wide > {4'd0, NUM_SAT}) ? NUM_SAT : acc_wide[12:0];
        end
        upd_pos = (pos_reg == 3'd7) ? 3'd7 : pos_reg + 3'd1;

        // A space ends the token as it stood; a final character ends it after the update.
        tok_cand = is_space ? cand_reg : upd_cand;
        tok_pos  = is_space ? pos_reg  : upd_pos;
        tok_acc  = is_space ? acc_reg  : upd_acc;
        do_end   = cmd_item && (is_space ? (pos_reg != 3'd0) : is_final);

        for (int k = 0; k < 6; k++) begin
            hit[k] = tok_cand[k] && (tok_pos == KW_LEN[k]);
        end
        tok_var = VAR_NONE;
        for (int k = KW_TEMP; k <= KW_TARGET; k++) begin
            if (hit[k]) begin
                tok_var = var_t'(3'(k - 1));
            end
        end

        kind_e   = kind_reg;
        var_e    = var_reg;
        verd_e   = verd_reg;
        timer_e  = timer_reg;
        status_e = status_reg;
        target_e = target_reg;
        if (verd_reg == VERD_PENDING) begin
            unique case (tok_idx_reg)
                2'd0: begin
                    if (hit[KW_GET]) begin
                        kind_e = CMD_GET;
                    end else if (hit[KW_SET]) begin
                        kind_e = CMD_SET;
                    end else begin
                        verd_e = VERD_FAIL;
                    end
                end
                2'd1: begin
                    if (tok_var == VAR_NONE || (kind_reg == CMD_SET && tok_var == VAR_TEMP)) begin
                        verd_e = VERD_FAIL;
                    end else begin
                        var_e = tok_var;
                        if (kind_reg == CMD_GET) begin
                            verd_e = VERD_OK;
                        end
                    end
                end
                2'd2: begin
                    verd_e = VERD_FAIL;
                    if (tok_cand[CAND_DIGIT]) begin
                        if (var_reg == VAR_TIMER && tok_acc <= {1'b0, timer_limit}) begin
                            timer_e = tok_acc[11:0];
                            verd_e  = VERD_OK;
                        end else if (var_reg == VAR_STATUS && tok_acc <= 13'd1) begin
                            status_e = tok_acc[0];
                            verd_e   = VERD_OK;
                        end else if (var_reg == VAR_TARGET && tok_acc >= {6'd0, target_low}
                                     && tok_acc <= {6'd0, target_high}) begin
                            target_e = tok_acc[6:0];
                            verd_e   = VERD_OK;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (!do_end) begin
            kind_e   = kind_reg;
            var_e    = var_reg;
            verd_e   = verd_reg;
            timer_e  = timer_reg;
            status_e = status_reg;
            target_e = target_reg;
        end

        // Reply selection for a final character.
        temp_wide = {12'd0, temp_reg};
        temp_rd   = temp_wide[11:0];
        if (temp_rd > 12'd1023) begin
            temp_rd = 12'd1023;
        end
        unique case (var_e)
            VAR_TEMP:   val = temp_rd;
            VAR_TIMER:  val = timer_reg;
            VAR_STATUS: val = {11'd0, status_reg};
            default:    val = {5'd0, target_reg};
        endcase

        rep_req       = '0;
        rep_req.load  = adv && final_item;
        rep_req.ok    = (verd_e == VERD_OK);
        rep_req.value = val;
        if (verd_e == VERD_OK) begin
            if (kind_e == CMD_SET) begin
                rep_req.txt = TXT_OK;
                rep_req.len = 3'd2;
            end else begin
                rep_req.num = 1'b1;
                if (val >= 12'd1000) begin
                    rep_req.len = 3'd4;
                end else if (val >= 12'd100) begin
                    rep_req.len = 3'd3;
                end else if (val >= 12'd10) begin
                    rep_req.len = 3'd2;
                end else begin
                    rep_req.len = 3'd1;
                end
            end
        end else begin
            rep_req.len = 3'd3;
            if (kind_e == CMD_NONE) begin
                rep_req.txt = TXT_CMD;
            end else if (var_e == VAR_NONE) begin
                rep_req.txt = TXT_VAR;
            end else begin
                rep_req.txt = TXT_INT;
            end
        end

        // Next state.
        smp_wide     = {{TEMP_BITS{1'b0}}, temp_sample};
        temp_next    = temp_reg;
        timer_next   = timer_e;
        status_next  = status_e;
        target_next  = target_e;
        tok_idx_next = tok_idx_reg;
        pos_next     = pos_reg;
        cand_next    = cand_reg;
        acc_next     = acc_reg;
        kind_next    = kind_e;
        var_next     = var_e;
        verd_next    = verd_e;
        if (req_type) begin
            temp_next = smp_wide[TEMP_BITS-1:0];
        end else if (final_item) begin
            tok_idx_next = 2'd0;
            pos_next     = 3'd0;
            cand_next    = CAND_ALL;
            acc_next     = 13'd0;
            kind_next    = CMD_NONE;
            var_next     = VAR_NONE;
            verd_next    = VERD_PENDING;
        end else if (do_end) begin
            tok_idx_next = (tok_idx_reg == 2'd3) ? 2'd3 : tok_idx_reg + 2'd1;
            pos_next     = 3'd0;
            cand_next    = CAND_ALL;
            acc_next     = 13'd0;
        end else if (!is_space) begin
            pos_next  = upd_pos;
            cand_next = upd_cand;
            acc_next  = upd_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg    <= '0;
            timer_reg   <= 12'd0;
            status_reg  <= 1'b0;
            target_reg  <= 7'd0;
            tok_idx_reg <= 2'd0;
            pos_reg     <= 3'd0;
            cand_reg    <= CAND_ALL;
            acc_reg     <= 13'd0;
            kind_reg    <= CMD_NONE;
            var_reg     <= VAR_NONE;
            verd_reg    <= VERD_PENDING;
        end else if (adv) begin
            temp_reg    <= temp_next;
            timer_reg   <= timer_next;
            status_reg  <= status_next;
            target_reg  <= target_next;
            tok_idx_reg <= tok_idx_next;
            pos_reg     <= pos_next;
            cand_reg    <= cand_next;
            acc_reg     <= acc_next;
            kind_reg    <= kind_next;
            var_reg     <= var_next;
            verd_reg    <= verd_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tcra_reply.sv @@
// Reply serializer: holds one reply and sends it one character per item.
`default_nettype none

module tcra_reply
    import tcra_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire reply_req_t rep_req,
    input  wire logic       m_tready,
    output logic            m_tvalid,
    output logic [7:0]      m_char,
    output logic            m_last,
    output logic            m_ok,
    output logic            rep_free
);

    logic [2:0]  cnt_reg, cnt_next;
    logic        num_reg, num_next;
    logic        ok_reg, ok_next;
    txt_t        txt_reg, txt_next;
    logic [11:0] rem_reg, rem_next;

    logic [1:0]  place;
    logic [3:0]  digit;
    logic        pop;

    always_comb begin
        place    = 2'(cnt_reg - 3'd1);
        digit    = digit_of(rem_reg, place);
        m_tvalid = (cnt_reg != 3'd0);
        m_char   = num_reg ? (CH_ZERO + {4'd0, digit}) : txt_reg[0];
        m_last   = (cnt_reg == 3'd1);
        m_ok     = ok_reg;
        pop      = m_tvalid && m_tready;
        rep_free = (cnt_reg == 3'd0) || (m_last && m_tready);

        cnt_next = cnt_reg;
        num_next = num_reg;
        ok_next  = ok_reg;
        txt_next = txt_reg;
        rem_next = rem_reg;
        if (rep_req.load) begin
            cnt_next = rep_req.len;
            num_next = rep_req.num;
            ok_next  = rep_req.ok;
            txt_next = rep_req.txt;
            rem_next = rep_req.value;
        end else if (pop) begin
            // Advance to the next character: shift text, strip the digit just sent.
            cnt_next = cnt_reg - 3'd1;
            txt_next = {8'h00, txt_reg[2:1]};
            rem_next = rem_reg - 12'({10'd0, digit} * pow10(place));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        ok_reg  <= ok_next;
        txt_reg <= txt_next;
        rem_reg <= rem_next;
    end

endmodule

`default_nettype wire

@@ hdl/text_command_register_access.sv @@
// Top level of the text command register access block: input register, parser, reply serializer.
`default_nettype none

// Command characters enter on the s_ stream, one per item, and are accepted at one per cycle
// unless a final character is held in the input register; each goes through that input
// register before it is parsed. A sample item (tuser high) only updates the temperature. The
// character marked tlast ends the command; its reply (OK, CMD, VAR, INT or a 1 to 4 digit
// decimal value) leaves on the m_ stream one character per cycle while m_tready is high, tlast
// on the last character and tuser high on success. The reply is loaded from the parser into
// the reply serializer's registers. The reply serializer holds one reply: a later final
// character waits in the input register until the current reply's last character is taken,
// so a steady stream of final characters (one-character commands, each answered CMD) is taken
// one reply at a time. Registers written on the cfg_ port: 0 timer limit (12 bits), 1 target
// low (7 bits), 2 target high (7 bits); write them only while the block is idle.

module text_command_register_access
    import tcra_pkg::*;
#(
    parameter int TEMP_BITS = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_byte [7:0], temp_sample [17:8], zero [23:18]
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // reply_char [7:0]
    output logic             m_tlast,
    output logic             m_tuser,   // success
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [11:0] cfg_wdata
);

    logic        in_vld_reg;
    logic        in_type_reg;
    logic [7:0]  in_char_reg;
    logic        in_final_reg;
    logic [9:0]  in_temp_reg;
    logic [11:0] timer_limit_reg;
    logic [6:0]  target_low_reg;
    logic [6:0]  target_high_reg;

    logic        adv;
    logic        rep_free;
    reply_req_t  rep_req;

    // Hold a final character until the serializer can take its reply.
    assign adv       = in_vld_reg && (in_type_reg || !in_final_reg || rep_free);
    assign s_tready  = !in_vld_reg || adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg  <= s_tuser;
            in_char_reg  <= s_tdata[7:0];
            in_final_reg <= s_tlast;
            in_temp_reg  <= s_tdata[17:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_limit_reg <= 12'd3600;
            target_low_reg  <= 7'd40;
            target_high_reg <= 7'd80;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_TIMER_LIMIT: timer_limit_reg <= cfg_wdata;
                CFG_TARGET_LOW:  target_low_reg  <= cfg_wdata[6:0];
                CFG_TARGET_HIGH: target_high_reg <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    tcra_parser #(
        .TEMP_BITS (TEMP_BITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .req_type    (in_type_reg),
        .char_byte   (in_char_reg),
        .is_final    (in_final_reg),
        .temp_sample (in_temp_reg),
        .timer_limit (timer_limit_reg),
        .target_low  (target_low_reg),
        .target_high (target_high_reg),
        .rep_req     (rep_req)
    );

    tcra_reply u_reply (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rep_req  (rep_req),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_char   (m_tdata),
        .m_last   (m_tlast),
        .m_ok     (m_tuser),
        .rep_free (rep_free)
    );

`ifndef SYNTHESIS
    a_reply_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser)))
        else $error("reply ended without its last character");

    a_reply_len: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_req.load |-> (rep_req.len != 3'd0 && rep_req.len <= 3'd4 && rep_free))
        else $error("reply loaded with a bad length or over a pending reply");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !adv) |=> (in_vld_reg && $stable(in_char_reg) && in_final_reg))
        else $error("stalled input item was lost or changed");
`endif

endmodule

`default_nettype wire
